>>> rtl/swer_pkg.sv
// Shared types and constants of the sliding-window event-rate core.
package swer_pkg;

  localparam int unsigned SLOT_W  = 32;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned SUM_W   = 28;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_RREAD = 7'b0000100,
    S_UPD   = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_LAST  = 7'b0100000,
    S_OUT   = 7'b1000000
  } swer_state_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic rd_en;
    logic rd_scan;
    logic upd;
    logic out_load;
  } swer_cmd_t;

  typedef struct packed {
    logic op;
    logic scan_last;
    logic out_free;
  } swer_sts_t;

endpackage

>>> rtl/sliding_window_event_rate_core.sv
// Sliding-window event-rate core: a record word passes through slot modulo by constant
// multiply, bucket read and bucket write before the next word is accepted.
// A query reads the buckets in order, one bucket read per cycle, and then presents its count;
// it holds in the output stage while an earlier count is stalled.
// One word is in flight at a time, and a finished count may still wait in the output register.
// Synchronous active-low reset marks every bucket unwritten and empties the output.
module sliding_window_event_rate_core #(
  parameter int unsigned BUCKETS = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [swer_pkg::SLOT_W-1:0] in_slot_now,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [swer_pkg::SUM_W-1:0]  out_window_count
);
  import swer_pkg::*;

  swer_cmd_t cmd;
  swer_sts_t sts;

  swer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swer_dp #(
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_operation     (in_operation),
    .in_slot_now      (in_slot_now),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_window_count (out_window_count),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

>>> rtl/swer_ctrl.sv
// Sequencer of the sliding-window event-rate core.
module swer_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  swer_pkg::swer_sts_t sts,
  output swer_pkg::swer_cmd_t cmd
);
  import swer_pkg::*;

  swer_state_t state_r, state_nxt;
  logic        accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.load     = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (sts.op == OP_QUERY) ? S_SCAN : S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        state_nxt    = S_RREAD;
      end
      S_RREAD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/swer_dp.sv
// Datapath of the sliding-window event-rate core: bucket store, slot modulo, window sum.
module swer_dp #(
  parameter int unsigned BUCKETS = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_operation,
  input  logic [swer_pkg::SLOT_W-1:0]  in_slot_now,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [swer_pkg::SUM_W-1:0]   out_window_count,
  input  swer_pkg::swer_cmd_t          cmd,
  output swer_pkg::swer_sts_t          sts
);
  import swer_pkg::*;

  localparam int unsigned AW     = $clog2(BUCKETS);
  localparam int unsigned EW     = SLOT_W + COUNT_W;
  localparam int unsigned PROD_W = 2 * SLOT_W + 1;
  localparam int unsigned SHIFT  = SLOT_W + AW;
  localparam logic [SLOT_W:0] MAGIC =
    (SLOT_W + 1)'(((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [AW-1:0] B_LO = AW'(BUCKETS);

  logic [EW-1:0]      mem [BUCKETS];
  logic [BUCKETS-1:0] wrt_r;

  logic [SLOT_W-1:0]  now_r;
  logic [PROD_W-1:0]  prod_r;
  logic [AW-1:0]      scan_r;
  logic               scan_rd_r;
  logic [EW-1:0]      rd_q_r;
  logic               wrt_q_r;
  logic [SUM_W-1:0]   acc_r;
  logic               out_valid_r;
  logic [SUM_W-1:0]   out_count_r;

  logic [AW-1:0]      idx;
  logic [AW-1:0]      rd_addr;
  logic [SLOT_W-1:0]  q_tag;
  logic [COUNT_W-1:0] q_cnt;
  logic [SLOT_W-1:0]  age;
  logic               in_win;
  logic [SUM_W:0]     sum;
  logic [SUM_W-1:0]   acc_nxt;
  logic [COUNT_W-1:0] cnt_nxt;

  assign idx     = now_r[AW-1:0] - (prod_r[SHIFT +: AW] * B_LO);
  assign rd_addr = cmd.rd_scan ? scan_r : idx;

  assign q_tag   = rd_q_r[EW-1:COUNT_W];
  assign q_cnt   = rd_q_r[COUNT_W-1:0];
  assign age     = now_r - q_tag;
  assign in_win  = wrt_q_r && (q_tag < now_r) && (age <= SLOT_W'(BUCKETS - 1));
  assign sum     = {1'b0, acc_r} + (SUM_W + 1)'(q_cnt);
  assign acc_nxt = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];

  always_comb begin
    if (!wrt_q_r || (q_tag != now_r)) begin
      cnt_nxt = COUNT_W'(1);
    end else if (q_cnt == COUNT_MAX) begin
      cnt_nxt = COUNT_MAX;
    end else begin
      cnt_nxt = q_cnt + COUNT_W'(1);
    end
  end

  assign sts.op        = in_operation;
  assign sts.scan_last = (scan_r == AW'(BUCKETS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid        = out_valid_r;
  assign out_window_count = out_count_r;

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      mem[idx] <= {now_r, cnt_nxt};
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r <= in_slot_now;
    end
    if (cmd.mod_step) begin
      prod_r <= PROD_W'(now_r) * PROD_W'(MAGIC);
    end
    if (cmd.rd_en) begin
      wrt_q_r <= wrt_r[rd_addr];
    end
    if (cmd.out_load) begin
      out_count_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrt_r       <= '0;
      scan_r      <= '0;
      scan_rd_r   <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scan_rd_r <= cmd.rd_en && cmd.rd_scan;
      if (cmd.upd) begin
        wrt_r[idx] <= 1'b1;
      end
      if (cmd.load) begin
        scan_r <= '0;
        acc_r  <= '0;
      end else begin
        if (cmd.rd_en && cmd.rd_scan && !sts.scan_last) begin
          scan_r <= scan_r + AW'(1);
        end
        if (scan_rd_r && in_win) begin
          acc_r <= acc_nxt;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
